@@ hw/rtl/fspc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feeder shot PID controller package
// Shared constants, register indexes, controller states and command struct.
// ----------------------------------------------------------------------------
package fspc_pkg;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SINGLE_MODE    = 3'd0;
	localparam logic [2:0] CFG_BURST_RATE     = 3'd1;
	localparam logic [2:0] CFG_GAIN_P         = 3'd2;
	localparam logic [2:0] CFG_GAIN_I         = 3'd3;
	localparam logic [2:0] CFG_GAIN_D         = 3'd4;
	localparam logic [2:0] CFG_INTEGRAL_LIMIT = 3'd5;

	localparam logic [15:0] GAIN_P_RESET = 16'd18;

	localparam logic [12:0] ANGLE_WRAP   = 13'd8191;
	localparam logic [5:0]  SINGLE_RATE  = 6'd10;
	localparam logic [13:0] RPM_PER_RATE = 14'd180;
	localparam logic [9:0]  READY_PWM    = 10'd685;

	localparam logic signed [37:0] P_LIMIT   = 38'sd8000;
	localparam logic signed [37:0] D_LIMIT   = 38'sd2000;
	localparam logic signed [38:0] OUT_LIMIT = 39'sd10000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_RATE,
		ST_ERR,
		ST_SUM,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ADD,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic capture;
		logic angle;
		logic rate;
		logic err;
		logic integ;
		logic mul_p;
		logic mul_i;
		logic mul_d;
		logic add;
		logic load_out;
	} ctl_cmd_t;

endpackage

@@ hw/rtl/fspc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feeder shot PID controller sequencer
// Steps the datapath through one tick and owns both channel handshakes.
// ----------------------------------------------------------------------------
module fspc_ctrl import fspc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output ctl_cmd_t cmd
);

	ctl_state_t state_q, state_next;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_next  = ST_ANGLE;
				end
			end
			ST_ANGLE: begin
				cmd.angle  = 1'b1;
				state_next = ST_RATE;
			end
			ST_RATE: begin
				cmd.rate   = 1'b1;
				state_next = ST_ERR;
			end
			ST_ERR: begin
				cmd.err    = 1'b1;
				state_next = ST_SUM;
			end
			ST_SUM: begin
				cmd.integ  = 1'b1;
				state_next = ST_MUL_P;
			end
			ST_MUL_P: begin
				cmd.mul_p  = 1'b1;
				state_next = ST_MUL_I;
			end
			ST_MUL_I: begin
				cmd.mul_i  = 1'b1;
				state_next = ST_MUL_D;
			end
			ST_MUL_D: begin
				cmd.mul_d  = 1'b1;
				state_next = ST_ADD;
			end
			ST_ADD: begin
				cmd.add    = 1'b1;
				state_next = ST_FINISH;
			end
			ST_FINISH: begin
				// The result register may still hold a beat the sink has not taken.
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ hw/rtl/fspc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feeder shot PID controller datapath
// Config registers, shot pacing state, PID state, shared multiplier and
// the result register.
// ----------------------------------------------------------------------------
module fspc_datapath import fspc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_cmd_t           cmd,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic [12:0]        rotor_angle,
	input  logic signed [15:0] rotor_speed,
	input  logic               flywheel_enable,
	input  logic [9:0]         flywheel_pwm_now,
	input  logic               load_angle,
	input  logic [19:0]        new_angle,
	output logic signed [14:0] drive_out,
	output logic [13:0]        target_rpm,
	output logic [19:0]        angle_left,
	output logic               flywheel_ready,
	output logic [9:0]         flywheel_pwm_cmd
);

	function automatic logic signed [37:0] sat38(input logic signed [37:0] v,
		input logic signed [37:0] lim);
		logic signed [37:0] r;
		r = v;
		if (v > lim) begin
			r = lim;
		end else if (v < -lim) begin
			r = -lim;
		end
		return r;
	endfunction

	// Configuration registers.
	logic        single_mode_q;
	logic [5:0]  burst_rate_q;
	logic [15:0] gain_p_q;
	logic [15:0] gain_i_q;
	logic [15:0] gain_d_q;
	logic [19:0] integral_limit_q;

	// Captured input beat.
	logic [12:0]        angle_q;
	logic signed [15:0] speed_q;
	logic               enable_q;
	logic [9:0]         pwm_now_q;
	logic               load_q;
	logic [19:0]        new_angle_q;

	// Loop state.
	logic [12:0]        prev_angle_q;
	logic [19:0]        remaining_q;
	logic signed [20:0] error_sum_q;
	logic signed [16:0] prev_error_q;

	// Per-tick working registers.
	logic [12:0]        step_q;
	logic               ready_q;
	logic [13:0]        target_q;
	logic signed [16:0] err_q;
	logic signed [17:0] diff_q;
	logic signed [37:0] prod_q;
	logic signed [37:0] p_q;
	logic signed [37:0] i_q;
	logic signed [38:0] acc_q;

	logic [13:0]        wrap_sum;
	logic [12:0]        step_next;
	logic               ready_next;
	logic [19:0]        rem_loaded;
	logic [5:0]         rate_next;
	logic [19:0]        rem_after;
	logic signed [21:0] sum_raw;
	logic signed [21:0] lim_pos;
	logic signed [21:0] lim_neg;
	logic signed [16:0] mul_a;
	logic signed [20:0] mul_b;
	logic signed [37:0] mul_prod;
	logic signed [37:0] d_sat;
	logic signed [38:0] acc_next;
	logic signed [14:0] drive_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_mode_q    <= 1'b1;
			burst_rate_q     <= '0;
			gain_p_q         <= GAIN_P_RESET;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			integral_limit_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SINGLE_MODE:    single_mode_q    <= cfg_data[0];
				CFG_BURST_RATE:     burst_rate_q     <= cfg_data[5:0];
				CFG_GAIN_P:         gain_p_q         <= cfg_data[15:0];
				CFG_GAIN_I:         gain_i_q         <= cfg_data[15:0];
				CFG_GAIN_D:         gain_d_q         <= cfg_data[15:0];
				CFG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Encoder step with wrap at the top of the angle range.
	assign wrap_sum   = {1'b0, ANGLE_WRAP} - {1'b0, prev_angle_q} + {1'b0, angle_q};
	assign step_next  = (angle_q >= prev_angle_q) ? (angle_q - prev_angle_q) : wrap_sum[12:0];
	assign ready_next = enable_q && (pwm_now_q == READY_PWM);
	assign rem_loaded = load_q ? new_angle_q : remaining_q;

	always_comb begin
		rate_next = '0;
		rem_after = '0;
		if (single_mode_q) begin
			if (remaining_q > {7'b0, step_q}) begin
				rem_after = remaining_q - {7'b0, step_q};
				rate_next = SINGLE_RATE;
			end
		end else begin
			rate_next = burst_rate_q;
		end
		if (!ready_q) begin
			rate_next = '0;
		end
	end

	assign sum_raw = {error_sum_q[20], error_sum_q} + {{5{err_q[16]}}, err_q};
	assign lim_pos = $signed({2'b00, integral_limit_q});
	assign lim_neg = -lim_pos;

	// One shared multiplier serves the three PID terms in turn.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.mul_p) begin
			mul_a = $signed({1'b0, gain_p_q});
			mul_b = {{4{err_q[16]}}, err_q};
		end else if (cmd.mul_i) begin
			mul_a = $signed({1'b0, gain_i_q});
			mul_b = error_sum_q;
		end else if (cmd.mul_d) begin
			mul_a = $signed({1'b0, gain_d_q});
			mul_b = {{3{diff_q[17]}}, diff_q};
		end
	end

	assign mul_prod = mul_a * mul_b;
	assign d_sat    = sat38(prod_q, D_LIMIT);
	assign acc_next = {p_q[37], p_q} + {i_q[37], i_q} + {d_sat[37], d_sat};

	always_comb begin
		drive_next = acc_q[14:0];
		if (acc_q > OUT_LIMIT) begin
			drive_next = OUT_LIMIT[14:0];
		end else if (acc_q < -OUT_LIMIT) begin
			drive_next = 15'(-OUT_LIMIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_angle_q <= '0;
			remaining_q  <= '0;
			error_sum_q  <= '0;
			prev_error_q <= '0;
		end else begin
			if (cmd.angle) begin
				prev_angle_q <= angle_q;
				remaining_q  <= ready_next ? rem_loaded : '0;
			end
			if (cmd.rate) begin
				remaining_q <= rem_after;
			end
			if (cmd.integ) begin
				if (sum_raw > lim_pos) begin
					error_sum_q <= lim_pos[20:0];
				end else if (sum_raw < lim_neg) begin
					error_sum_q <= lim_neg[20:0];
				end else begin
					error_sum_q <= sum_raw[20:0];
				end
				prev_error_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			angle_q     <= rotor_angle;
			speed_q     <= rotor_speed;
			enable_q    <= flywheel_enable;
			pwm_now_q   <= flywheel_pwm_now;
			load_q      <= load_angle;
			new_angle_q <= new_angle;
		end
		if (cmd.angle) begin
			step_q  <= step_next;
			ready_q <= ready_next;
		end
		if (cmd.rate) begin
			target_q <= 14'(rate_next) * RPM_PER_RATE;
		end
		if (cmd.err) begin
			err_q <= $signed({3'b000, target_q}) - {speed_q[15], speed_q};
		end
		if (cmd.integ) begin
			diff_q <= {err_q[16], err_q} - {prev_error_q[16], prev_error_q};
		end
		if (cmd.mul_p) begin
			prod_q <= mul_prod;
		end
		if (cmd.mul_i) begin
			p_q    <= sat38(prod_q, P_LIMIT);
			prod_q <= mul_prod;
		end
		if (cmd.mul_d) begin
			i_q    <= prod_q;
			prod_q <= mul_prod;
		end
		if (cmd.add) begin
			acc_q <= acc_next;
		end
		if (cmd.load_out) begin
			drive_out        <= drive_next;
			target_rpm       <= target_q;
			angle_left       <= remaining_q;
			flywheel_ready   <= ready_q;
			flywheel_pwm_cmd <= enable_q ? READY_PWM : '0;
		end
	end

endmodule

@@ hw/rtl/feeder_shot_pid_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feeder shot PID controller
// Flywheel readiness, shot pacing and a clamped PID speed loop, one beat
// per control tick.
// ----------------------------------------------------------------------------
// A result beat is shown once the sequencer has walked its input beat through
// the angle, rate, error, sum, P, I and D multiply, add and finish states. A
// new beat is taken only in idle: ticks share the single 17x21 multiplier.
// The result register lets the next input be taken while a result waits.
// Reset clears the loop state and restores config defaults; no item is held.
// ----------------------------------------------------------------------------
module feeder_shot_pid_controller_unit import fspc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [12:0]        rotor_angle,
	input  logic signed [15:0] rotor_speed,
	input  logic               flywheel_enable,
	input  logic [9:0]         flywheel_pwm_now,
	input  logic               load_angle,
	input  logic [19:0]        new_angle,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [14:0] drive_out,
	output logic [13:0]        target_rpm,
	output logic [19:0]        angle_left,
	output logic               flywheel_ready,
	output logic [9:0]         flywheel_pwm_cmd
);

	ctl_cmd_t cmd;

	fspc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	fspc_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.rotor_angle      (rotor_angle),
		.rotor_speed      (rotor_speed),
		.flywheel_enable  (flywheel_enable),
		.flywheel_pwm_now (flywheel_pwm_now),
		.load_angle       (load_angle),
		.new_angle        (new_angle),
		.drive_out        (drive_out),
		.target_rpm       (target_rpm),
		.angle_left       (angle_left),
		.flywheel_ready   (flywheel_ready),
		.flywheel_pwm_cmd (flywheel_pwm_cmd)
	);

endmodule
